### rtl/rpwu_pkg.sv
// Shared types and constants for the Rprop weight update block.
// No dependencies; imported by the top level.
package rpwu_pkg;

  localparam int STEP_W  = 30;
  localparam int STATE_W = 32;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int CREDIT_W   = 3;

  // Step sizes in unsigned Q6.24.
  localparam logic [STEP_W-1:0] STEP_RESET = 30'd1677722;   // 0.1
  localparam logic [STEP_W-1:0] STEP_MAX   = 30'd838860800; // 50.0
  localparam logic [STEP_W-1:0] STEP_MIN   = 30'd17;        // 1e-6
  // Smallest step whose growth by 6/5 would pass STEP_MAX.
  localparam logic [STEP_W-1:0] GROW_LIMIT = 30'd699050668;
  // floor(x / 5) == (x * RECIP5) >> 34 for any 32-bit x.
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
  localparam int RECIP5_SHIFT = 34;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  // One memory word per weight.
  typedef struct packed {
    logic [1:0]        sign;
    logic [STEP_W-1:0] step;
  } state_t;

endpackage

### rtl/rpwu_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module rpwu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rprop_weight_update.sv
// Rprop (iRprop-) weight update, one weight per word.
// Depends on rpwu_pkg and rpwu_ram.
//
// Usage: each input word carries a weight index, the current weight and its
// gradient (signed Q8.24). Each input word yields exactly one result word on
// the out_ channel: the new weight, saturated, and a flag that is set when a
// sign change of the gradient suppressed the move. Words leave in the order
// they arrived.
// Per-weight step size and last gradient sign live in one memory with
// registered read data. A write that coincides with the read of the same
// weight is forwarded, so indices may repeat back to back.
// From acceptance to the result showing on out_valid a word passes memory
// read, step update, weight add and saturation. Throughput is one word per
// cycle while the receiver keeps up, as set by the memory read-modify-write.
// After reset the block sweeps the memory, writing the initial step size and
// a cleared sign to every entry; in_ready stays low until the sweep is done.
// A four-entry output queue decouples the sides. in_ready falls once four
// words are in flight, so a stalled receiver halts the input after at most
// four words and nothing is lost.
module rprop_weight_update
  import rpwu_pkg::*;
#(
  parameter int WEIGHT_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        in_weight_index,
  input  logic signed [31:0] in_weight_value,
  input  logic signed [31:0] in_gradient,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_weight,
  output logic               out_update_skipped
);

  localparam int AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;

  logic in_fire, out_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Clearing pass after reset.
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(WEIGHT_COUNT - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Input decode.
  logic  in_range;
  sign_t in_gsign;
  assign in_range = 17'(in_weight_index) < 17'(WEIGHT_COUNT);
  always_comb begin
    if (in_gradient == 32'sd0) begin
      in_gsign = SIGN_NONE;
    end else if (in_gradient[31]) begin
      in_gsign = SIGN_NEG;
    end else begin
      in_gsign = SIGN_POS;
    end
  end

  // Stage 1: memory data arrives, step and sign are updated.
  logic               s1_valid_r;
  logic [11:0]        s1_idx_r;
  logic               s1_in_range_r;
  logic signed [31:0] s1_w_r;
  sign_t              s1_gsign_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  state_t        ram_wdata;
  logic [STATE_W-1:0] ram_rdata;

  state_t fwd_state_r;
  logic   fwd_hit_r;

  state_t cur_state, new_state;
  logic   prev_signed, sign_same, sign_flip, s1_write;
  logic [61:0]       grow_prod;
  logic [STEP_W:0]   grown;
  logic [STEP_W-1:0] grown_capped, shrunk, halved;

  assign cur_state   = fwd_hit_r ? fwd_state_r : state_t'(ram_rdata);
  assign prev_signed = (cur_state.sign == SIGN_POS) || (cur_state.sign == SIGN_NEG);
  assign sign_same   = (s1_gsign_r != SIGN_NONE) && prev_signed
                       && (cur_state.sign == s1_gsign_r);
  assign sign_flip   = (s1_gsign_r != SIGN_NONE) && prev_signed
                       && (cur_state.sign != s1_gsign_r);

  // Growth by 6/5: step + floor(step / 5), the quotient by reciprocal.
  assign grow_prod    = {32'd0, cur_state.step} * {30'd0, RECIP5};
  assign grown        = {1'b0, cur_state.step}
                        + (STEP_W+1)'(grow_prod[61:RECIP5_SHIFT]);
  assign grown_capped = (cur_state.step >= GROW_LIMIT) ? STEP_MAX : grown[STEP_W-1:0];

  assign halved = cur_state.step >> 1;
  assign shrunk = (halved < STEP_MIN) ? STEP_MIN : halved;

  always_comb begin
    new_state = cur_state;
    priority if (sign_same) begin
      new_state.step = grown_capped;
      new_state.sign = s1_gsign_r;
    end else if (sign_flip) begin
      new_state.step = shrunk;
      new_state.sign = SIGN_NONE;
    end else begin
      new_state.sign = s1_gsign_r;
    end
  end

  assign s1_write = s1_valid_r && s1_in_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      // The memory returns the old word when the same entry is written in
      // the cycle of the read, so the fresh word is taken from here instead.
      fwd_hit_r  <= in_fire && in_range && s1_write && (s1_idx_r == in_weight_index);
    end
    fwd_state_r <= new_state;
    if (in_fire) begin
      s1_idx_r      <= in_weight_index;
      s1_in_range_r <= in_range;
      s1_w_r        <= in_weight_value;
      s1_gsign_r    <= in_gsign;
    end
  end

  always_comb begin
    if (clr_active_r) begin
      ram_we         = 1'b1;
      ram_waddr      = clr_addr_r;
      ram_wdata.sign = SIGN_NONE;
      ram_wdata.step = STEP_RESET;
    end else begin
      ram_we    = s1_write;
      ram_waddr = AW'(s1_idx_r);
      ram_wdata = new_state;
    end
  end

  rpwu_ram #(
    .WIDTH (STATE_W),
    .DEPTH (WEIGHT_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(in_weight_index)),
    .rdata (ram_rdata)
  );

  // Stage 2: move the weight and saturate.
  logic               s2_valid_r;
  logic signed [31:0] s2_w_r;
  logic [STEP_W-1:0]  s2_step_r;
  sign_t              s2_gsign_r;
  logic               s2_move_r;
  logic               s2_skip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_w_r     <= s1_w_r;
    s2_step_r  <= new_state.step;
    s2_gsign_r <= s1_gsign_r;
    s2_move_r  <= s1_in_range_r && !sign_flip;
    s2_skip_r  <= s1_in_range_r && sign_flip;
  end

  logic signed [32:0] step_ext, moved;
  logic signed [31:0] result_w;

  assign step_ext = {3'b000, s2_step_r};

  always_comb begin
    unique case (s2_gsign_r)
      SIGN_POS: moved = 33'(s2_w_r) - step_ext;
      SIGN_NEG: moved = 33'(s2_w_r) + step_ext;
      default:  moved = 33'(s2_w_r);
    endcase
    if (!s2_move_r) begin
      result_w = s2_w_r;
    end else if (moved[32] != moved[31]) begin
      result_w = moved[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      result_w = moved[31:0];
    end
  end

  // Output queue and in-flight word count.
  logic signed [31:0]  outq_w_r    [OUTQ_DEPTH];
  logic                outq_skip_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]  outq_wr_ptr_r, outq_rd_ptr_r;
  logic [CREDIT_W-1:0] outq_count_r, credit_r, credit_nxt;

  assign credit_nxt = credit_r + CREDIT_W'(in_fire) - CREDIT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outq_wr_ptr_r <= '0;
      outq_rd_ptr_r <= '0;
      outq_count_r  <= '0;
      credit_r      <= '0;
    end else begin
      credit_r     <= credit_nxt;
      outq_count_r <= outq_count_r + CREDIT_W'(s2_valid_r) - CREDIT_W'(out_fire);
      if (s2_valid_r) begin
        outq_wr_ptr_r <= outq_wr_ptr_r + OUTQ_AW'(1);
      end
      if (out_fire) begin
        outq_rd_ptr_r <= outq_rd_ptr_r + OUTQ_AW'(1);
      end
    end
    if (s2_valid_r) begin
      outq_w_r[outq_wr_ptr_r]    <= result_w;
      outq_skip_r[outq_wr_ptr_r] <= s2_skip_r;
    end
  end

  assign in_ready           = !clr_active_r && (credit_r < CREDIT_W'(OUTQ_DEPTH));
  assign out_valid          = outq_count_r != '0;
  assign out_new_weight     = outq_w_r[outq_rd_ptr_r];
  assign out_update_skipped = outq_skip_r[outq_rd_ptr_r];

endmodule

### rtl/rpwu_checker.sv
// Port-level checks for the Rprop weight update block, bound to the top level.
// No package dependencies.
module rpwu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_weight,
  input logic        out_update_skipped
);

  // A result word waiting for the receiver holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_new_weight)
                                   && $stable(out_update_skipped)))
    else $error("result word changed while stalled");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // Reset starts the memory sweep, during which no word is taken.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready straight after reset");

  // Every accepted word has a result waiting once it has passed stage 1, stage 2 and the output queue.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##3 out_valid)
    else $error("no result three cycles after an accepted word");

endmodule

bind rprop_weight_update rpwu_checker u_rpwu_checker (.*);
